// File: hw/rtl/scst_pkg.sv
package scst_pkg;

   localparam int MAX_LITERALS = 8;
   localparam int LITERAL_BITS = 16;

   localparam int FIELD_BITS = 16;
   localparam int COUNT_FIELD_BITS = 4;
   localparam int CNT_BITS = $clog2(MAX_LITERALS + 1);

   localparam logic [LITERAL_BITS-1:0] LIT_ZERO = '0;
   localparam logic [LITERAL_BITS-1:0] LIT_MIN = LITERAL_BITS'(1) << (LITERAL_BITS - 1);

   typedef enum logic [1:0] {
      MODE_CLEAR    = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_ASSIGN   = 2'd2,
      MODE_UNASSIGN = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_SATISFIED     = 2'd0,
      STATUS_CONTRADICTION = 2'd1,
      STATUS_UNKNOWN       = 2'd2
   } status_type;

   typedef logic [LITERAL_BITS-1:0] lit_type;
   typedef logic [MAX_LITERALS-1:0] slot_mask_type;

   typedef struct packed {
      logic was_satisfied;
      logic table_full;
   } flags_type;

   typedef struct packed {
      status_type                  status;
      logic                        is_unit;
      logic [COUNT_FIELD_BITS-1:0] active_count;
      logic [FIELD_BITS-1:0]       some_literal;
   } summary_type;

   // sign-extend the port field, keep the low literal bits
   function automatic lit_type lit_from_field(input logic [FIELD_BITS-1:0] f);
      logic [31:0] x;
      x = {{(32 - FIELD_BITS){f[FIELD_BITS-1]}}, f};
      return x[LITERAL_BITS-1:0];
   endfunction

   // sign-extend a literal to the port field width
   function automatic logic [FIELD_BITS-1:0] lit_to_field(input lit_type v);
      logic [LITERAL_BITS+FIELD_BITS-1:0] x;
      x = {{FIELD_BITS{v[LITERAL_BITS-1]}}, v};
      return x[FIELD_BITS-1:0];
   endfunction

endpackage

// File: hw/rtl/sat_clause_state_tracker.sv
// sat_clause_state_tracker: keeps one cnf clause and reports its state
//
// request channel: req_valid / req_stall with req_mode and req_literal; a beat
// is taken at a rising edge where req_valid is high and req_stall is low.
// modes are clear, add literal, assign literal and unassign variable.
// response channel: rsp_valid / rsp_stall; exactly one response beat per
// request beat, in order, giving the clause state after that request.
//
// a request beat lands in the input register, is evaluated against the clause
// state once the result register is free, and its response is then held in
// the output register until taken. throughput is one beat per cycle while
// rsp_stall is low, set by the combinational compare of all slots against
// the literal and its negation.
//
// reset (synchronous, active high) empties the clause and drops any beat in
// flight. while rsp_stall is high the held response stays put; the input
// register still takes one more beat, then req_stall rises until the response
// is taken.
module sat_clause_state_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_literal,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_clause_status,
   output logic        rsp_is_unit,
   output logic [3:0]  rsp_active_count,
   output logic [15:0] rsp_some_active_literal,
   output logic        rsp_was_satisfied,
   output logic        rsp_table_full
);

   // input register
   logic                      in_valid_ff;
   logic                      in_valid_in;
   scst_pkg::mode_type        mode_ff;
   scst_pkg::lit_type         lit_ff;

   // result register
   logic                      out_valid_ff;
   logic                      out_valid_in;
   scst_pkg::summary_type     summary_ff;
   scst_pkg::flags_type       flags_ff;

   logic                      req_take;
   logic                      out_free;
   logic                      fire;

   scst_pkg::lit_type         slot_lit_in [scst_pkg::MAX_LITERALS];
   scst_pkg::slot_mask_type   present_in;
   scst_pkg::slot_mask_type   falsified_in;
   scst_pkg::lit_type         sat_lit_in;
   scst_pkg::flags_type       flags;
   scst_pkg::summary_type     summary;

   // result register frees up when empty or being drained this cycle
   assign out_free = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= scst_pkg::mode_type'(req_mode);
         lit_ff <= scst_pkg::lit_from_field(req_literal);
      end
      if (fire) begin
         summary_ff <= summary;
         flags_ff <= flags;
      end
   end

   // clause state and the per-mode update
   scst_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .mode         (mode_ff),
      .lit          (lit_ff),
      .slot_lit_in  (slot_lit_in),
      .present_in   (present_in),
      .falsified_in (falsified_in),
      .sat_lit_in   (sat_lit_in),
      .flags        (flags)
   );

   // status of the clause as it stands after the beat
   scst_summary u_summary (
      .slot_lit  (slot_lit_in),
      .present   (present_in),
      .falsified (falsified_in),
      .sat_lit   (sat_lit_in),
      .summary   (summary)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_clause_status = summary_ff.status;
   assign rsp_is_unit = summary_ff.is_unit;
   assign rsp_active_count = summary_ff.active_count;
   assign rsp_some_active_literal = summary_ff.some_literal;
   assign rsp_was_satisfied = flags_ff.was_satisfied;
   assign rsp_table_full = flags_ff.table_full;

endmodule

// File: hw/rtl/scst_core.sv
module scst_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  scst_pkg::mode_type              mode,
   input  scst_pkg::lit_type               lit,
   output scst_pkg::lit_type               slot_lit_in [scst_pkg::MAX_LITERALS],
   output scst_pkg::slot_mask_type         present_in,
   output scst_pkg::slot_mask_type         falsified_in,
   output scst_pkg::lit_type               sat_lit_in,
   output scst_pkg::flags_type             flags
);

   scst_pkg::lit_type       slot_lit_ff [scst_pkg::MAX_LITERALS];
   scst_pkg::slot_mask_type present_ff;
   scst_pkg::slot_mask_type falsified_ff;
   scst_pkg::lit_type       sat_lit_ff;

   scst_pkg::lit_type       neg;
   logic                    lit_ok;
   scst_pkg::slot_mask_type eq_pos;
   scst_pkg::slot_mask_type eq_neg;
   scst_pkg::slot_mask_type active;
   scst_pkg::slot_mask_type free;
   scst_pkg::slot_mask_type free_low;

   always_comb begin
      neg = scst_pkg::LIT_ZERO - lit;
      lit_ok = (lit != scst_pkg::LIT_ZERO) && (lit != scst_pkg::LIT_MIN);
      for (int i = 0; i < scst_pkg::MAX_LITERALS; i++) begin
         eq_pos[i] = (slot_lit_ff[i] == lit);
         eq_neg[i] = (slot_lit_ff[i] == neg);
      end
      active = present_ff & ~falsified_ff;
      free = ~present_ff;
      // lowest free slot as a one-hot mask
      free_low = free & (~free + scst_pkg::slot_mask_type'(1));
   end

   always_comb begin
      slot_lit_in = slot_lit_ff;
      present_in = present_ff;
      falsified_in = falsified_ff;
      sat_lit_in = sat_lit_ff;
      flags = '0;
      if (fire) begin
         unique case (mode)
            scst_pkg::MODE_CLEAR: begin
               present_in = '0;
               falsified_in = '0;
               sat_lit_in = scst_pkg::LIT_ZERO;
            end
            scst_pkg::MODE_ADD: begin
               if (lit_ok && !(|(present_ff & eq_pos))) begin
                  if (free == '0) begin
                     flags.table_full = 1'b1;
                  end else begin
                     present_in = present_ff | free_low;
                     falsified_in = falsified_ff & ~free_low;
                     for (int i = 0; i < scst_pkg::MAX_LITERALS; i++) begin
                        if (free_low[i]) begin
                           slot_lit_in[i] = lit;
                        end
                     end
                  end
               end
            end
            scst_pkg::MODE_ASSIGN: begin
               if (lit_ok) begin
                  if (sat_lit_ff != scst_pkg::LIT_ZERO) begin
                     flags.was_satisfied = 1'b1;
                  end else begin
                     falsified_in = falsified_ff | (active & eq_neg);
                     if (|(active & eq_pos)) begin
                        sat_lit_in = lit;
                     end
                  end
               end
            end
            scst_pkg::MODE_UNASSIGN: begin
               if (lit_ok) begin
                  if (sat_lit_ff == lit || sat_lit_ff == neg) begin
                     sat_lit_in = scst_pkg::LIT_ZERO;
                  end
                  falsified_in = falsified_ff & ~(present_ff & (eq_pos | eq_neg));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // literal slots carry no reset, only present slots are ever read
   always_ff @(posedge clock) begin
      slot_lit_ff <= slot_lit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         falsified_ff <= '0;
         sat_lit_ff <= scst_pkg::LIT_ZERO;
      end else begin
         present_ff <= present_in;
         falsified_ff <= falsified_in;
         sat_lit_ff <= sat_lit_in;
      end
   end

endmodule

// File: hw/rtl/scst_summary.sv
module scst_summary (
   input  scst_pkg::lit_type       slot_lit [scst_pkg::MAX_LITERALS],
   input  scst_pkg::slot_mask_type present,
   input  scst_pkg::slot_mask_type falsified,
   input  scst_pkg::lit_type       sat_lit,
   output scst_pkg::summary_type   summary
);

   scst_pkg::slot_mask_type        active;
   scst_pkg::slot_mask_type        active_low;
   logic [scst_pkg::CNT_BITS-1:0]  count;
   logic [31:0]                    count_wide;
   scst_pkg::lit_type              first;

   always_comb begin
      active = present & ~falsified;
      active_low = active & (~active + scst_pkg::slot_mask_type'(1));
      count = '0;
      first = scst_pkg::LIT_ZERO;
      for (int i = 0; i < scst_pkg::MAX_LITERALS; i++) begin
         count = count + scst_pkg::CNT_BITS'(active[i]);
         first = first | (slot_lit[i] & {scst_pkg::LITERAL_BITS{active_low[i]}});
      end
      count_wide = 32'(count);

      if (sat_lit != scst_pkg::LIT_ZERO) begin
         summary.status = scst_pkg::STATUS_SATISFIED;
      end else if (count_wide == 32'd0) begin
         summary.status = scst_pkg::STATUS_CONTRADICTION;
      end else begin
         summary.status = scst_pkg::STATUS_UNKNOWN;
      end
      summary.is_unit = (count_wide == 32'd1);
      // saturate at the field maximum
      if (count_wide > 32'd15) begin
         summary.active_count = scst_pkg::COUNT_FIELD_BITS'(15);
      end else begin
         summary.active_count = count_wide[scst_pkg::COUNT_FIELD_BITS-1:0];
      end
      summary.some_literal = scst_pkg::lit_to_field(first);
   end

endmodule

// File: hw/rtl/scst_checker.sv
module scst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_mode,
   input logic [15:0] req_literal,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_clause_status,
   input logic        rsp_is_unit,
   input logic [3:0]  rsp_active_count,
   input logic [15:0] rsp_some_active_literal,
   input logic        rsp_was_satisfied,
   input logic        rsp_table_full
);

   // a stalled response beat is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // unit flag follows the active count
   a_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_unit == (rsp_active_count == 4'd1)))
      else $error("unit flag disagrees with active count");

   // no active literal: never unknown, and no literal reported
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active_count == 4'd0 |->
         rsp_clause_status != scst_pkg::STATUS_UNKNOWN && rsp_some_active_literal == 16'd0)
      else $error("empty clause reported as unknown or with a literal");

   // an active literal is never zero
   a_active_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active_count != 4'd0 |-> rsp_some_active_literal != 16'd0)
      else $error("active literal reported as zero");

   // an already satisfied clause stays satisfied and only one flag can be set
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_satisfied |->
         rsp_clause_status == scst_pkg::STATUS_SATISFIED && !rsp_table_full)
      else $error("inconsistent flags on response");

endmodule

bind sat_clause_state_tracker scst_checker u_scst_checker (.*);
